[rtl/core/tkm_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the timestamp merge.
package tkm_pkg;

  localparam int MAX_SOURCES = 8;
  localparam int SRC_W       = 3;
  localparam int CNT_W       = 4;
  localparam int TIME_W      = 64;
  localparam int DATA_W      = 64;
  localparam int TDATA_W     = 136;
  localparam int PAD_W       = TDATA_W - SRC_W - TIME_W - DATA_W;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_END    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SORT_CMP,
    ST_SORT_SHIFT,
    ST_MERGE_CMP,
    ST_MERGE_SHIFT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SHIFT_NONE,
    SHIFT_INSERT,
    SHIFT_REFILL,
    SHIFT_POP
  } shift_op_t;

  typedef enum logic {
    CMP_HEAD,
    CMP_ITEM
  } cmp_sel_t;

  typedef struct packed {
    logic             capture;
    logic             head_wr;
    logic             clear_list;
    logic             cmp_en;
    cmp_sel_t         cmp_sel;
    shift_op_t        shift_op;
    logic             emit;
    logic [SRC_W-1:0] sort_idx;
  } cmd_t;

  typedef struct packed {
    logic             item_op;
    logic [SRC_W-1:0] item_src;
    logic [SRC_W-1:0] front_src;
    logic [CNT_W-1:0] open_cnt;
    logic             out_busy;
  } stat_t;

endpackage

[rtl/core/tkm_ctrl.sv]
// Merge controller: start-up bookkeeping, sort sequencing and per-word command state machine.
module tkm_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic                     cfg_wr_en,
  input  logic [tkm_pkg::CNT_W-1:0] cfg_wr_data,
  input  tkm_pkg::stat_t           stat,
  output tkm_pkg::cmd_t            cmd
);
  import tkm_pkg::*;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       src_cnt_r;
  logic [CNT_W-1:0]       sort_cnt_r;
  logic [SRC_W-1:0]       sort_idx_r;
  logic [MAX_SOURCES-1:0] arrived_r;
  logic [MAX_SOURCES-1:0] ended_r;
  logic                   merging_r;

  logic [CNT_W-1:0]       cnt_eff;
  logic [MAX_SOURCES-1:0] src_bit;
  logic [MAX_SOURCES-1:0] all_mask;
  logic [MAX_SOURCES-1:0] new_seen;
  logic                   seen;
  logic                   in_range;
  logic                   start_ok;
  logic                   startup_done;
  logic                   merge_ok;
  logic                   last_idx;
  logic                   arrived_cur;

  // count register clamped to 1..MAX_SOURCES
  always_comb begin
    if (src_cnt_r == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (src_cnt_r > CNT_W'(MAX_SOURCES)) begin
      cnt_eff = CNT_W'(MAX_SOURCES);
    end else begin
      cnt_eff = src_cnt_r;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_SOURCES; i++) begin
      all_mask[i] = (CNT_W'(i) < cnt_eff);
    end
  end

  assign src_bit      = {{(MAX_SOURCES-1){1'b0}}, 1'b1} << stat.item_src;
  assign seen         = |((arrived_r | ended_r) & src_bit);
  assign new_seen     = arrived_r | ended_r | src_bit;
  assign in_range     = ({1'b0, stat.item_src} < cnt_eff);
  assign start_ok     = !merging_r && in_range && !seen;
  assign startup_done = ((new_seen & all_mask) == all_mask);
  assign merge_ok     = merging_r && (stat.open_cnt != '0) &&
                        (stat.item_src == stat.front_src);
  assign last_idx     = ({1'b0, sort_idx_r} == (sort_cnt_r - CNT_W'(1)));
  assign arrived_cur  = arrived_r[sort_idx_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (start_ok) begin
          state_nxt = startup_done ? ST_SORT_CMP : ST_IDLE;
        end else if (merge_ok) begin
          state_nxt = (stat.item_op == OP_RECORD) ? ST_MERGE_CMP : ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SORT_CMP: begin
        if (arrived_cur) begin
          state_nxt = ST_SORT_SHIFT;
        end else if (last_idx) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SORT_SHIFT:  state_nxt = last_idx ? ST_EMIT : ST_SORT_CMP;
      ST_MERGE_CMP:   state_nxt = ST_MERGE_SHIFT;
      ST_MERGE_SHIFT: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!stat.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready     = 1'b0;
    cmd.capture    = 1'b0;
    cmd.head_wr    = 1'b0;
    cmd.clear_list = 1'b0;
    cmd.cmp_en     = 1'b0;
    cmd.cmp_sel    = CMP_HEAD;
    cmd.shift_op   = SHIFT_NONE;
    cmd.emit       = 1'b0;
    cmd.sort_idx   = sort_idx_r;
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_DECIDE: begin
        cmd.head_wr    = start_ok && (stat.item_op == OP_RECORD);
        cmd.clear_list = start_ok && startup_done;
        if (!start_ok && merge_ok && (stat.item_op == OP_END)) cmd.shift_op = SHIFT_POP;
      end
      ST_SORT_CMP: begin
        cmd.cmp_en  = arrived_cur;
        cmd.cmp_sel = CMP_HEAD;
      end
      ST_SORT_SHIFT:  cmd.shift_op = SHIFT_INSERT;
      ST_MERGE_CMP: begin
        cmd.cmp_en  = 1'b1;
        cmd.cmp_sel = CMP_ITEM;
      end
      ST_MERGE_SHIFT: cmd.shift_op = SHIFT_REFILL;
      ST_EMIT:        cmd.emit = !stat.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      src_cnt_r  <= CNT_W'(MAX_SOURCES);
      sort_cnt_r <= '0;
      sort_idx_r <= '0;
      arrived_r  <= '0;
      ended_r    <= '0;
      merging_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) src_cnt_r <= cfg_wr_data;
      if ((state_r == ST_DECIDE) && start_ok) begin
        if (stat.item_op == OP_RECORD) begin
          arrived_r <= arrived_r | src_bit;
        end else begin
          ended_r <= ended_r | src_bit;
        end
        if (startup_done) begin
          merging_r  <= 1'b1;
          sort_cnt_r <= cnt_eff;
          sort_idx_r <= '0;
        end
      end
      if (((state_r == ST_SORT_CMP) && !arrived_cur && !last_idx) ||
          ((state_r == ST_SORT_SHIFT) && !last_idx)) begin
        sort_idx_r <= sort_idx_r + SRC_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  // merge phase, once entered, lasts until reset
  assert property (@(posedge clk) disable iff (!rst_n) merging_r |=> merging_r)
    else $error("merge phase left without reset");
  // sorting only runs after start-up has completed
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SORT_CMP || state_r == ST_SORT_SHIFT) |-> merging_r)
    else $error("sort step outside merge phase");
`endif

endmodule

[rtl/core/tkm_datapath.sv]
// Merge datapath: item capture, per-source heads, ordered slot list, comparators and output register.
module tkm_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_op,
  input  logic [tkm_pkg::SRC_W-1:0]  in_src,
  input  logic [tkm_pkg::TIME_W-1:0] in_time,
  input  logic [tkm_pkg::DATA_W-1:0] in_data,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [tkm_pkg::SRC_W-1:0]  out_src,
  output logic [tkm_pkg::TIME_W-1:0] out_time,
  output logic [tkm_pkg::DATA_W-1:0] out_data,
  output logic                       out_fin,
  input  tkm_pkg::cmd_t              cmd,
  output tkm_pkg::stat_t             stat
);
  import tkm_pkg::*;

  logic              item_op_r;
  logic [SRC_W-1:0]  item_src_r;
  logic [TIME_W-1:0] item_time_r;
  logic [DATA_W-1:0] item_data_r;

  logic [TIME_W-1:0] head_time_r [MAX_SOURCES];
  logic [DATA_W-1:0] head_data_r [MAX_SOURCES];

  logic [SRC_W-1:0]  slot_src_r  [MAX_SOURCES];
  logic [TIME_W-1:0] slot_time_r [MAX_SOURCES];
  logic [DATA_W-1:0] slot_data_r [MAX_SOURCES];
  logic [SRC_W-1:0]  slot_src_nxt  [MAX_SOURCES];
  logic [TIME_W-1:0] slot_time_nxt [MAX_SOURCES];
  logic [DATA_W-1:0] slot_data_nxt [MAX_SOURCES];
  logic [CNT_W-1:0]  open_cnt_r, open_cnt_nxt;

  logic [SRC_W-1:0]  cand_src_r;
  logic [TIME_W-1:0] cand_time_r;
  logic [DATA_W-1:0] cand_data_r;
  logic [SRC_W-1:0]  k_r;

  logic [SRC_W-1:0]  cand_src;
  logic [TIME_W-1:0] cand_time;
  logic [DATA_W-1:0] cand_data;
  logic [MAX_SOURCES-1:0] le;
  logic              lt1;
  logic [CNT_W-1:0]  ins_k;
  logic [CNT_W-1:0]  ref_k;
  logic [SRC_W-1:0]  k_nxt;

  logic              out_valid_r;
  logic [SRC_W-1:0]  out_src_r;
  logic [TIME_W-1:0] out_time_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_fin_r;

  // compare stage: candidate against every open slot
  always_comb begin
    if (cmd.cmp_sel == CMP_HEAD) begin
      cand_src  = cmd.sort_idx;
      cand_time = head_time_r[cmd.sort_idx];
      cand_data = head_data_r[cmd.sort_idx];
    end else begin
      cand_src  = item_src_r;
      cand_time = item_time_r;
      cand_data = item_data_r;
    end
    for (int p = 0; p < MAX_SOURCES; p++) begin
      le[p] = (CNT_W'(p) < open_cnt_r) && (slot_time_r[p] <= cand_time);
    end
    lt1   = (open_cnt_r >= CNT_W'(2)) && (slot_time_r[1] < cand_time);
    ins_k = '0;
    ref_k = '0;
    for (int p = 0; p < MAX_SOURCES; p++) begin
      ins_k = ins_k + CNT_W'(le[p]);
      if (p > 0) ref_k = ref_k + CNT_W'(le[p]);
    end
    // refill keeps the front unless the new time passes the runner-up
    if (cmd.cmp_sel == CMP_HEAD) begin
      k_nxt = ins_k[SRC_W-1:0];
    end else begin
      k_nxt = lt1 ? ref_k[SRC_W-1:0] : '0;
    end
  end

  // shift stage
  always_comb begin
    open_cnt_nxt = open_cnt_r;
    for (int j = 0; j < MAX_SOURCES; j++) begin
      slot_src_nxt[j]  = slot_src_r[j];
      slot_time_nxt[j] = slot_time_r[j];
      slot_data_nxt[j] = slot_data_r[j];
      case (cmd.shift_op)
        SHIFT_INSERT: begin
          if (SRC_W'(j) == k_r) begin
            slot_src_nxt[j]  = cand_src_r;
            slot_time_nxt[j] = cand_time_r;
            slot_data_nxt[j] = cand_data_r;
          end else if (SRC_W'(j) > k_r) begin
            slot_src_nxt[j]  = slot_src_r[SRC_W'(j-1)];
            slot_time_nxt[j] = slot_time_r[SRC_W'(j-1)];
            slot_data_nxt[j] = slot_data_r[SRC_W'(j-1)];
          end
        end
        SHIFT_REFILL: begin
          if (SRC_W'(j) == k_r) begin
            slot_src_nxt[j]  = cand_src_r;
            slot_time_nxt[j] = cand_time_r;
            slot_data_nxt[j] = cand_data_r;
          end else if (SRC_W'(j) < k_r) begin
            slot_src_nxt[j]  = slot_src_r[SRC_W'(j+1)];
            slot_time_nxt[j] = slot_time_r[SRC_W'(j+1)];
            slot_data_nxt[j] = slot_data_r[SRC_W'(j+1)];
          end
        end
        SHIFT_POP: begin
          if (j < MAX_SOURCES - 1) begin
            slot_src_nxt[j]  = slot_src_r[SRC_W'(j+1)];
            slot_time_nxt[j] = slot_time_r[SRC_W'(j+1)];
            slot_data_nxt[j] = slot_data_r[SRC_W'(j+1)];
          end
        end
        default: ;
      endcase
    end
    case (cmd.shift_op)
      SHIFT_INSERT: open_cnt_nxt = open_cnt_r + CNT_W'(1);
      SHIFT_POP:    open_cnt_nxt = open_cnt_r - CNT_W'(1);
      default:      ;
    endcase
    if (cmd.clear_list) open_cnt_nxt = '0;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op_r   <= in_op;
      item_src_r  <= in_src;
      item_time_r <= in_time;
      item_data_r <= in_data;
    end
    if (cmd.head_wr) begin
      head_time_r[item_src_r] <= item_time_r;
      head_data_r[item_src_r] <= item_data_r;
    end
    if (cmd.cmp_en) begin
      cand_src_r  <= cand_src;
      cand_time_r <= cand_time;
      cand_data_r <= cand_data;
      k_r         <= k_nxt;
    end
    for (int j = 0; j < MAX_SOURCES; j++) begin
      slot_src_r[j]  <= slot_src_nxt[j];
      slot_time_r[j] <= slot_time_nxt[j];
      slot_data_r[j] <= slot_data_nxt[j];
    end
    if (cmd.emit) begin
      if (open_cnt_r == '0) begin
        out_src_r  <= '0;
        out_time_r <= '0;
        out_data_r <= '0;
        out_fin_r  <= 1'b1;
      end else begin
        out_src_r  <= slot_src_r[0];
        out_time_r <= slot_time_r[0];
        out_data_r <= slot_data_r[0];
        out_fin_r  <= 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      open_cnt_r <= open_cnt_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_src   = out_src_r;
  assign out_time  = out_time_r;
  assign out_data  = out_data_r;
  assign out_fin   = out_fin_r;

  assign stat.item_op   = item_op_r;
  assign stat.item_src  = item_src_r;
  assign stat.front_src = slot_src_r[0];
  assign stat.open_cnt  = open_cnt_r;
  assign stat.out_busy  = out_valid_r && !out_ready;

`ifndef SYNTHESIS
  // the two front slots are always in time order
  assert property (@(posedge clk) disable iff (!rst_n)
    (open_cnt_r >= CNT_W'(2)) |-> (slot_time_r[0] <= slot_time_r[1]))
    else $error("slot list out of order at front");
  // an end mark drops exactly one open source
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift_op == SHIFT_POP) |=> (open_cnt_r == $past(open_cnt_r) - CNT_W'(1)))
    else $error("pop did not remove one entry");
  // a finished word is only shown when no source is open
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fin_r) |-> (open_cnt_r == '0))
    else $error("finished word with open sources");
`endif

endmodule

[rtl/core/timestamp_k_way_merge_top.sv]
// Top level of the timestamp k-way merge: stream ports, controller and datapath.
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+----------------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata: source, timestamp, payload; tuser: opcode
//  out_    | out | out_tvalid/tready  | tdata: source, timestamp, payload; tuser: finished
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data: source_count
//
// One word at a time. An ignored word is captured and decided only; an end mark is decided with a
// pop of the front slot, then emitted; a refill record is decided, compared against all open heads,
// shifted into the slot list and emitted. The word that completes start-up runs the insertion
// sort over the configured sources. The sort and the refill share the compare stage and the slot shifter.
// A result waits in the output register; a new word is taken meanwhile and only its emit
// step stalls while out_tvalid is high and out_tready low. rst_n is synchronous, active low.
module timestamp_k_way_merge_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tkm_pkg::TDATA_W-1:0] in_tdata,   // [2:0] source, [66:3] timestamp,
                                                  // [130:67] payload, rest zero
  input  logic                        in_tuser,   // [0] opcode (0 record, 1 end)
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [tkm_pkg::TDATA_W-1:0] out_tdata,  // [2:0] out_source, [66:3] out_timestamp,
                                                  // [130:67] out_payload, rest zero
  output logic                        out_tuser,  // [0] finished
  input  logic                        cfg_wr_en,
  input  logic [tkm_pkg::CNT_W-1:0]   cfg_wr_data
);
  import tkm_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic [SRC_W-1:0]  out_src;
  logic [TIME_W-1:0] out_time;
  logic [DATA_W-1:0] out_data;

  tkm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stat        (stat),
    .cmd         (cmd)
  );

  // unpack the input word; pad bits above the payload are not used
  tkm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_op     (in_tuser),
    .in_src    (in_tdata[SRC_W-1:0]),
    .in_time   (in_tdata[SRC_W+TIME_W-1:SRC_W]),
    .in_data   (in_tdata[SRC_W+TIME_W+DATA_W-1:SRC_W+TIME_W]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_src   (out_src),
    .out_time  (out_time),
    .out_data  (out_data),
    .out_fin   (out_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

  assign out_tdata = {{PAD_W{1'b0}}, out_data, out_time, out_src};

endmodule
